FILE: design/f2i_pkg.sv
`default_nettype none
package f2i_pkg;

  // Target type codes.
  localparam logic [3:0] KIND_I8   = 4'd0;
  localparam logic [3:0] KIND_I16  = 4'd1;
  localparam logic [3:0] KIND_I32  = 4'd2;
  localparam logic [3:0] KIND_I64  = 4'd3;
  localparam logic [3:0] KIND_U8   = 4'd4;
  localparam logic [3:0] KIND_U16  = 4'd5;
  localparam logic [3:0] KIND_U32  = 4'd6;
  localparam logic [3:0] KIND_U64  = 4'd7;
  localparam logic [3:0] KIND_BOOL = 4'd8;

  localparam logic [10:0] EXP_MAX  = 11'h7FF;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  localparam logic [10:0] EXP_ONE  = 11'd1075;

  // Decoded request carried from the first stage to the shifter.
  typedef struct packed {
    logic [3:0]  kind;
    logic        neg;
    logic        is_nan;
    logic        nonzero;
    logic        big;
    logic        below_one;
    logic        shift_left;
    logic [5:0]  shamt;
    logic [52:0] mant;
  } f2i_dec_t;

  // Magnitude handed from the shifter to the clamp stage.
  typedef struct packed {
    logic [3:0]  kind;
    logic        neg;
    logic        is_nan;
    logic        nonzero;
    logic        big;
    logic [63:0] mag;
  } f2i_mag_t;

endpackage
`default_nettype wire

FILE: design/f2i_decode.sv
`default_nettype none
module f2i_decode (
  input  wire logic             clk,
  input  wire logic             in_valid,
  input  wire logic [3:0]       target_kind,
  input  wire logic [63:0]      double_bits,
  output      logic             dec_valid,
  output      f2i_pkg::f2i_dec_t dec,
  input  wire logic             rst
);

  logic [10:0] exp;
  logic [51:0] frac;
  f2i_pkg::f2i_dec_t dec_next;

  // Split the double and work out the shift direction and amount.
  always_comb begin
    exp  = double_bits[62:52];
    frac = double_bits[51:0];
    dec_next.kind       = target_kind;
    dec_next.neg        = double_bits[63];
    dec_next.is_nan     = (exp == f2i_pkg::EXP_MAX) && (frac != '0);
    dec_next.nonzero    = (exp != '0) || (frac != '0);
    dec_next.big        = (exp == f2i_pkg::EXP_MAX) || (exp > f2i_pkg::EXP_ONE + 11'd11);
    dec_next.below_one  = exp < f2i_pkg::EXP_BIAS;
    dec_next.shift_left = exp >= f2i_pkg::EXP_ONE;
    if (exp >= f2i_pkg::EXP_ONE) begin
      dec_next.shamt = 6'(exp - f2i_pkg::EXP_ONE);
    end else begin
      dec_next.shamt = 6'(f2i_pkg::EXP_ONE - exp);
    end
    dec_next.mant = {1'b1, frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid;
    end
    dec <= dec_next;
  end

endmodule
`default_nettype wire

FILE: design/f2i_shift.sv
`default_nettype none
module f2i_shift (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              dec_valid,
  input  wire f2i_pkg::f2i_dec_t dec,
  output      logic              mag_valid,
  output      f2i_pkg::f2i_mag_t mag
);

  f2i_pkg::f2i_mag_t mag_next;

  // Align the significand to the integer point, dropping fraction bits.
  always_comb begin
    mag_next.kind    = dec.kind;
    mag_next.neg     = dec.neg;
    mag_next.is_nan  = dec.is_nan;
    mag_next.nonzero = dec.nonzero;
    mag_next.big     = dec.big;
    if (dec.big || dec.below_one) begin
      mag_next.mag = '0;
    end else if (dec.shift_left) begin
      mag_next.mag = {11'd0, dec.mant} << dec.shamt[3:0];
    end else begin
      mag_next.mag = {11'd0, dec.mant} >> dec.shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else begin
      mag_valid <= dec_valid;
    end
    mag <= mag_next;
  end

endmodule
`default_nettype wire

FILE: design/f2i_clamp.sv
`default_nettype none
module f2i_clamp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              mag_valid,
  input  wire f2i_pkg::f2i_mag_t mag,
  output      logic              res_valid,
  output      logic [63:0]       res
);

  logic [63:0] lim;
  logic [63:0] maxv;
  logic [63:0] res_next;

  // Pick the signed limit 2^(N-1) and the unsigned maximum for the target width.
  always_comb begin
    unique case (mag.kind[1:0])
      2'd0: begin
        lim  = 64'h0000_0000_0000_0080;
        maxv = 64'h0000_0000_0000_00FF;
      end
      2'd1: begin
        lim  = 64'h0000_0000_0000_8000;
        maxv = 64'h0000_0000_0000_FFFF;
      end
      2'd2: begin
        lim  = 64'h0000_0000_8000_0000;
        maxv = 64'h0000_0000_FFFF_FFFF;
      end
      2'd3: begin
        lim  = 64'h8000_0000_0000_0000;
        maxv = 64'hFFFF_FFFF_FFFF_FFFF;
      end
    endcase
  end

  // Clamp to target range, apply sign; NaN gives 0, BOOL gives the nonzero flag.
  always_comb begin
    res_next = '0;
    if (mag.is_nan) begin
      res_next = '0;
    end else if (mag.kind == f2i_pkg::KIND_BOOL) begin
      res_next = {63'd0, mag.nonzero};
    end else if (mag.kind[3:2] == 2'b00) begin
      if (mag.neg) begin
        res_next = (mag.big || mag.mag > lim) ? 64'd0 - lim : 64'd0 - mag.mag;
      end else begin
        res_next = (mag.big || mag.mag > lim - 64'd1) ? lim - 64'd1 : mag.mag;
      end
    end else if (mag.kind[3:2] == 2'b01) begin
      if (mag.neg) begin
        res_next = '0;
      end else begin
        res_next = (mag.big || mag.mag > maxv) ? maxv : mag.mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= mag_valid;
    end
    res <= res_next;
  end

endmodule
`default_nettype wire

FILE: design/f64_to_int_saturating_convert.sv
`default_nettype none
// Saturating double-to-integer converter. A request is taken whenever start
// is high (busy is always low), one per cycle, and its result appears on
// int_bits with done high after it has passed the three register stages:
// decode, alignment shift, and clamp. Results cannot be held off, so the
// receiver must take each one in its cycle.
module f64_to_int_saturating_convert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [3:0]  target_kind,
  input  wire logic [63:0] double_bits,
  output      logic        done,
  output      logic [63:0] int_bits
);

  logic              dec_valid;
  f2i_pkg::f2i_dec_t dec;
  logic              mag_valid;
  f2i_pkg::f2i_mag_t mag;

  assign busy = 1'b0;

  f2i_decode u_decode (
    .clk(clk), .in_valid(start), .target_kind(target_kind),
    .double_bits(double_bits), .dec_valid(dec_valid), .dec(dec), .rst(rst)
  );

  f2i_shift u_shift (
    .clk(clk), .rst(rst), .dec_valid(dec_valid), .dec(dec),
    .mag_valid(mag_valid), .mag(mag)
  );

  f2i_clamp u_clamp (
    .clk(clk), .rst(rst), .mag_valid(mag_valid), .mag(mag),
    .res_valid(done), .res(int_bits)
  );

  // Every request shows up as a result with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##3 done) else $error("result missing");
  // NaN in the clamp stage always gives zero.
  a_nan: assert property (@(posedge clk) disable iff (rst)
    mag_valid && mag.is_nan |=> int_bits == 64'd0) else $error("NaN not zero");
  // Unsigned targets never get a negative value; this checks the U64 target.
  a_uns: assert property (@(posedge clk) disable iff (rst)
    mag_valid && mag.kind == f2i_pkg::KIND_U64 && mag.neg |=> int_bits == 64'd0)
    else $error("negative unsigned");

endmodule
`default_nettype wire
